// ===== rtl/olid_pkg.sv =====
// olid_pkg: shared types and codes for the ordered list insert/delete unit
// no dependencies; imported by olid_ram users and the top level

package olid_pkg;

    localparam int CNT_W  = 8;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int STS_W  = 2;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_SHIFT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_SWAP  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

    localparam logic [2:0] REG_CAPACITY = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_SWAP_WAIT,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/olid_ram.sv =====
// olid_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module olid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ordered_list_insert_delete_unit.sv =====
// ordered_list_insert_delete_unit: bounded ordered list of 32-bit words with a count
// depends on olid_pkg and olid_ram
// append, errors and last-entry deletes go straight to finish; read and swap wait on the ram read
// insert and delete-shift move the entries from position to the end, one entry moved per cycle
// a new word is taken only after the previous result has been handed to the output register
// reset (aresetn low, synchronous): count cleared, capacity 128, no result pending

module ordered_list_insert_delete_unit
    import olid_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // operation[2:0], position[9:3], value[41:10]
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[1:0], new_count[9:2], read_value[41:10]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [12:0] DEPTH_C = 13'(DEPTH);

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  wdst_reg, wdst_next;
    logic              rd_act_reg, rd_act_next;
    logic              pend_reg, pend_next;
    logic [STS_W-1:0]  sts_reg, sts_next;
    logic [WORD_W-1:0] rdv_reg, rdv_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [STS_W-1:0]  m_sts_reg, m_sts_next;
    logic [CNT_W-1:0]  m_cnt_reg, m_cnt_next;
    logic [WORD_W-1:0] m_rdv_reg, m_rdv_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic [OP_W-1:0]   in_op;
    logic [CNT_W-1:0]  in_pos;
    logic [WORD_W-1:0] in_val;
    logic              full;
    logic              cfg_wr;

    assign in_op  = s_tdata[2:0];
    assign in_pos = {1'b0, s_tdata[9:3]};
    assign in_val = s_tdata[41:10];
    assign full   = ({5'b0, count_reg} >= DEPTH_C) || (count_reg >= cap_reg);

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY[0]);
    assign prdata = (paddr[2] == REG_CAPACITY[0]) ? {24'b0, cap_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 8'd128;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[7:0];
        end
    end

    olid_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_act_reg   <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_act_reg   <= rd_act_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        cur_reg   <= cur_next;
        wdst_reg  <= wdst_next;
        sts_reg   <= sts_next;
        rdv_reg   <= rdv_next;
        m_sts_reg <= m_sts_next;
        m_cnt_reg <= m_cnt_next;
        m_rdv_reg <= m_rdv_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        cur_next      = cur_reg;
        wdst_next     = wdst_reg;
        rd_act_next   = rd_act_reg;
        pend_next     = pend_reg;
        sts_next      = sts_reg;
        rdv_next      = rdv_reg;
        m_tvalid_next = m_tvalid_reg;
        m_sts_next    = m_sts_reg;
        m_cnt_next    = m_cnt_reg;
        m_rdv_next    = m_rdv_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(wdst_reg);
        ram_wdata     = ram_rdata;
        ram_raddr     = AW'(cur_reg);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    pos_next    = in_pos;
                    val_next    = in_val;
                    sts_next    = STS_DONE;
                    rdv_next    = '0;
                    rd_act_next = 1'b0;
                    pend_next   = 1'b0;
                    state_next  = ST_FINISH;
                    case (in_op)
                        OP_APPEND: begin
                            if (full) begin
                                sts_next = STS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = in_val;
                                count_next = count_reg + 8'd1;
                            end
                        end
                        OP_INSERT: begin
                            if (in_pos > count_reg) begin
                                sts_next = STS_RANGE;
                            end else if (full) begin
                                sts_next = STS_FULL;
                            end else if (in_pos == count_reg) begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = in_val;
                                count_next = count_reg + 8'd1;
                            end else begin
                                cur_next    = count_reg - 8'd1;
                                rd_act_next = 1'b1;
                                state_next  = ST_SHIFT_UP;
                            end
                        end
                        OP_DEL_SHIFT: begin
                            if (in_pos >= count_reg) begin
                                sts_next = STS_RANGE;
                            end else if (in_pos == count_reg - 8'd1) begin
                                count_next = count_reg - 8'd1;
                            end else begin
                                cur_next    = in_pos + 8'd1;
                                rd_act_next = 1'b1;
                                state_next  = ST_SHIFT_DN;
                            end
                        end
                        OP_DEL_SWAP: begin
                            if (in_pos >= count_reg) begin
                                sts_next = STS_RANGE;
                            end else if (in_pos == count_reg - 8'd1) begin
                                count_next = count_reg - 8'd1;
                            end else begin
                                ram_raddr  = AW'(count_reg - 8'd1);
                                state_next = ST_SWAP_WAIT;
                            end
                        end
                        OP_READ: begin
                            if (in_pos >= count_reg) begin
                                sts_next = STS_RANGE;
                            end else begin
                                ram_raddr  = AW'(in_pos);
                                state_next = ST_READ_WAIT;
                            end
                        end
                        default: begin
                            sts_next = STS_RANGE;
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                // read entry cur, write it one place up from the registered read data
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (rd_act_reg) begin
                    pend_next = 1'b1;
                    wdst_next = cur_reg + 8'd1;
                    if (cur_reg == pos_reg) begin
                        rd_act_next = 1'b0;
                    end else begin
                        cur_next = cur_reg - 8'd1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(pos_reg);
                        ram_wdata  = val_reg;
                        count_next = count_reg + 8'd1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SHIFT_DN: begin
                // read entry cur, write it one place down from the registered read data
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (rd_act_reg) begin
                    pend_next = 1'b1;
                    wdst_next = cur_reg - 8'd1;
                    if (cur_reg == count_reg - 8'd1) begin
                        rd_act_next = 1'b0;
                    end else begin
                        cur_next = cur_reg + 8'd1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - 8'd1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SWAP_WAIT: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(pos_reg);
                count_next = count_reg - 8'd1;
                state_next = ST_FINISH;
            end
            ST_READ_WAIT: begin
                rdv_next   = ram_rdata;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_sts_next    = sts_reg;
                    m_cnt_next    = count_reg;
                    m_rdv_next    = rdv_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_rdv_reg, m_cnt_reg, m_sts_reg};

    count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {5'b0, count_reg} <= DEPTH_C)
        else $error("entry count above storage depth");

    one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while previous one in progress");

    count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 8'd1) || (count_reg == $past(count_reg) - 8'd1))
        else $error("entry count moved by more than one");

    result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish state");

endmodule
